// ===== rtl/mds_pkg.sv =====
package mds_pkg;

    localparam logic [7:0] SPACE_CHAR = 8'd32;
    localparam logic [7:0] DOT_CHAR   = 8'd46;
    localparam logic [7:0] DASH_CHAR  = 8'd45;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_FEED = 1'b1;

    localparam int OP_W = 2;

    // Work carried from the front to the back through the queue
    typedef enum logic [OP_W-1:0] {
        OP_LOAD,
        OP_LOOKUP,
        OP_WORD_SPACE
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_READ
    } t_back_state;

endpackage

// ===== rtl/morse_stream_decoder.sv =====
// Morse stream decoder. Load requests (req_type 0) write a letter into a trie
// of 2 << MAX_CODE_LEN nodes, indexed by (1 << length) | pattern with the first
// symbol in the MSB, dot 0 and dash 1; feed requests (req_type 1) carry one
// character of Morse text, and the block returns at most one result per
// request: a decoded letter on a space or end of stream, a word space (32)
// after three spaces in a row, or not_found for a code that has no node in
// the table or runs past MAX_CODE_LEN symbols. A front stage takes every
// request, keeps the pending code and space count and queues table work; a
// back stage owns the table memories and the result register. A load holds
// the back stage while it is taken from the queue, then writes one prefix
// node per cycle on the single write port; a lookup is a registered memory
// read, then the result, and a word space only the result. The two-entry
// queue lets the front keep taking requests while the back works, so feed
// requests that give no result flow at one per cycle while the queue has
// room. After reset the back stage sweeps all 2 << MAX_CODE_LEN table nodes
// once (128 at the default), and the input stays not ready until it is done.
module morse_stream_decoder
    import mds_pkg::*;
#(
    parameter int MAX_CODE_LEN = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_char_in,
    input  logic [5:0] i_load_pattern,
    input  logic [2:0] i_load_len,
    input  logic       i_end_of_stream,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_not_found
);

    localparam int NODE_W  = MAX_CODE_LEN + 1;
    localparam int ENTRY_W = NODE_W + OP_W + 18;

    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    logic               clear_busy;
    logic [ENTRY_W-1:0] entry_in;
    logic [ENTRY_W-1:0] entry_out;

    // front: accept requests, track the pending code and the space run
    mds_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NODE_W       (NODE_W),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_char_in       (i_char_in),
        .i_load_pattern  (i_load_pattern),
        .i_load_len      (i_load_len),
        .i_end_of_stream (i_end_of_stream),
        .i_clear_busy    (clear_busy),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_entry         (entry_in)
    );

    // hold table work in order between the two stages
    mds_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry_in),
        .i_pop   (pop),
        .o_data  (entry_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: table writes, lookups and the result register
    mds_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NODE_W       (NODE_W),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (entry_out),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_clear_busy (clear_busy),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_char   (o_out_char),
        .o_not_found  (o_not_found)
    );

endmodule

// ===== rtl/mds_queue.sv =====
module mds_queue
    import mds_pkg::*;
#(
    parameter int WIDTH = 27
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    // two-entry FIFO between front and back
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/mds_front.sv =====
module mds_front
    import mds_pkg::*;
#(
    parameter int MAX_CODE_LEN = 6,
    parameter int NODE_W       = MAX_CODE_LEN + 1,
    parameter int ENTRY_W      = NODE_W + OP_W + 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [7:0]         i_char_in,
    input  logic [5:0]         i_load_pattern,
    input  logic [2:0]         i_load_len,
    input  logic               i_end_of_stream,
    input  logic               i_clear_busy,
    input  logic               i_q_full,
    output logic               o_push,
    output logic [ENTRY_W-1:0] o_entry
);

    localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);

    logic [MAX_CODE_LEN-1:0] r_code_bits, n_code_bits;
    logic [CNT_W-1:0]        r_code_count, n_code_count;
    logic                    r_code_ovf, n_code_ovf;
    logic [1:0]              r_space_run, n_space_run;

    logic                    in_fire;
    logic                    pending;
    logic                    too_long;
    logic                    is_dash;
    logic [5:0]              pat_masked;
    logic [NODE_W-1:0]       lookup_node;
    t_op                     e_op;

    assign o_ready    = !i_q_full && !i_clear_busy;
    assign in_fire    = i_valid && o_ready;
    assign pending    = (r_code_count != '0) || r_code_ovf;
    assign too_long   = 32'(i_load_len) > MAX_CODE_LEN;
    assign is_dash    = (i_char_in == DASH_CHAR);
    assign pat_masked = i_load_pattern & ~(6'h3F << i_load_len);
    assign lookup_node = (NODE_W'(1) << r_code_count) | NODE_W'(r_code_bits);

    assign o_entry = {e_op, i_char_in, pat_masked, i_load_len, r_code_ovf, lookup_node};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits  <= '0;
            r_code_count <= '0;
            r_code_ovf   <= 1'b0;
            r_space_run  <= 2'd0;
        end else begin
            r_code_bits  <= n_code_bits;
            r_code_count <= n_code_count;
            r_code_ovf   <= n_code_ovf;
            r_space_run  <= n_space_run;
        end
    end

    always_comb begin
        n_code_bits  = r_code_bits;
        n_code_count = r_code_count;
        n_code_ovf   = r_code_ovf;
        n_space_run  = r_space_run;
        o_push       = 1'b0;
        e_op         = OP_LOOKUP;
        if (in_fire) begin
            if (i_req_type == REQ_LOAD) begin
                // drop loads longer than the table depth
                if (!too_long) begin
                    o_push = 1'b1;
                    e_op   = OP_LOAD;
                end
            end else if (i_end_of_stream) begin
                n_space_run = 2'd0;
                if (pending) begin
                    o_push       = 1'b1;
                    n_code_bits  = '0;
                    n_code_count = '0;
                    n_code_ovf   = 1'b0;
                end
            end else if (i_char_in == DOT_CHAR || is_dash) begin
                n_space_run = 2'd0;
                if (32'(r_code_count) >= MAX_CODE_LEN) begin
                    n_code_ovf = 1'b1;
                end else begin
                    n_code_bits  = MAX_CODE_LEN'({r_code_bits, is_dash});
                    n_code_count = r_code_count + CNT_W'(1);
                end
            end else if (i_char_in == SPACE_CHAR) begin
                if (pending) begin
                    o_push       = 1'b1;
                    n_space_run  = 2'd1;
                    n_code_bits  = '0;
                    n_code_count = '0;
                    n_code_ovf   = 1'b0;
                end else if (r_space_run == 2'd2) begin
                    o_push      = 1'b1;
                    e_op        = OP_WORD_SPACE;
                    n_space_run = 2'd0;
                end else begin
                    n_space_run = r_space_run + 2'd1;
                end
            end else begin
                n_space_run = 2'd0;
            end
        end
    end

endmodule

// ===== rtl/mds_back.sv =====
module mds_back
    import mds_pkg::*;
#(
    parameter int MAX_CODE_LEN = 6,
    parameter int NODE_W       = MAX_CODE_LEN + 1,
    parameter int ENTRY_W      = NODE_W + OP_W + 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [ENTRY_W-1:0] i_entry,
    input  logic               i_q_empty,
    output logic               o_pop,
    output logic               o_clear_busy,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_char,
    output logic               o_not_found
);

    localparam int NODE_COUNT = 2 << MAX_CODE_LEN;
    localparam int CALC_W     = (NODE_W > 8) ? NODE_W : 8;

    // entry fields, most significant first
    t_op               e_op;
    logic [7:0]        e_letter;
    logic [5:0]        e_pat;
    logic [2:0]        e_len;
    logic              e_ovf;
    logic [NODE_W-1:0] e_node;

    assign e_op     = t_op'(i_entry[ENTRY_W-1 -: OP_W]);
    assign e_letter = i_entry[NODE_W+17 -: 8];
    assign e_pat    = i_entry[NODE_W+9 -: 6];
    assign e_len    = i_entry[NODE_W+3 -: 3];
    assign e_ovf    = i_entry[NODE_W];
    assign e_node   = i_entry[NODE_W-1:0];

    logic [7:0]        r_letter_mem [NODE_COUNT];
    logic              r_present_mem [NODE_COUNT];

    t_back_state       r_state, n_state;
    logic [NODE_W-1:0] r_clr_addr, n_clr_addr;
    logic [2:0]        r_k, n_k;
    logic [2:0]        r_len, n_len;
    logic [5:0]        r_pat, n_pat;
    logic [7:0]        r_letter, n_letter;
    logic              r_ovf, n_ovf;
    logic              r_rd_present;
    logic [7:0]        r_rd_letter;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_char, n_out_char;
    logic              r_out_nf, n_out_nf;

    logic              out_free;
    logic              pres_we;
    logic              pres_wd;
    logic              let_we;
    logic [7:0]        let_wd;
    logic [NODE_W-1:0] wr_addr;
    logic              rd_en;
    logic [CALC_W-1:0] load_node_w;
    logic [NODE_W-1:0] load_node;

    assign o_clear_busy = (r_state == ST_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_not_found  = r_out_nf;
    assign out_free     = !r_out_valid || i_ready;

    // prefix node k of the loaded code: (1 << k) | (pattern >> (len - k))
    assign load_node_w = (CALC_W'(1) << r_k) | (CALC_W'(r_pat) >> (r_len - r_k));
    assign load_node   = load_node_w[NODE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_len      <= n_len;
        r_pat      <= n_pat;
        r_letter   <= n_letter;
        r_ovf      <= n_ovf;
        r_out_char <= n_out_char;
        r_out_nf   <= n_out_nf;
    end

    always_ff @(posedge i_clk) begin
        if (pres_we) begin
            r_present_mem[wr_addr] <= pres_wd;
        end
        if (let_we) begin
            r_letter_mem[wr_addr] <= let_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_present <= r_present_mem[e_node];
            r_rd_letter  <= r_letter_mem[e_node];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_k         = r_k;
        n_len       = r_len;
        n_pat       = r_pat;
        n_letter    = r_letter;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_nf    = r_out_nf;
        o_pop       = 1'b0;
        pres_we     = 1'b0;
        pres_wd     = 1'b0;
        let_we      = 1'b0;
        let_wd      = SPACE_CHAR;
        wr_addr     = r_clr_addr;
        rd_en       = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                // only the root starts present; every letter reads as space
                pres_we    = 1'b1;
                let_we     = 1'b1;
                pres_wd    = (r_clr_addr == NODE_W'(1));
                n_clr_addr = r_clr_addr + NODE_W'(1);
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    case (e_op)
                        OP_LOAD: begin
                            o_pop    = 1'b1;
                            n_k      = 3'd0;
                            n_len    = e_len;
                            n_pat    = e_pat;
                            n_letter = e_letter;
                            n_state  = ST_LOAD;
                        end
                        OP_LOOKUP: begin
                            o_pop   = 1'b1;
                            rd_en   = 1'b1;
                            n_ovf   = e_ovf;
                            n_state = ST_READ;
                        end
                        OP_WORD_SPACE: begin
                            if (out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_char  = SPACE_CHAR;
                                n_out_nf    = 1'b0;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                pres_we = 1'b1;
                pres_wd = 1'b1;
                wr_addr = load_node;
                if (r_k == r_len) begin
                    let_we  = 1'b1;
                    let_wd  = r_letter;
                    n_state = ST_IDLE;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_ovf || !r_rd_present) begin
                        n_out_char = 8'd0;
                        n_out_nf   = 1'b1;
                    end else begin
                        n_out_char = r_rd_letter;
                        n_out_nf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
